// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the pressure compensation block
// Holds the transaction payload structs, register indexes and the formula
// constants of the integer compensation algorithm.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_OSS     = 2'd0;
  localparam logic [1:0] REG_AC1_AC4 = 2'd1;
  localparam logic [1:0] REG_AC5_B2  = 2'd2;
  localparam logic [1:0] REG_MC_MD   = 2'd3;
  localparam int unsigned CFG_INDEX_W = 2;

  // Request kinds.
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // Formula constants.
  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] B4_OFFSET  = 32'd32768;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] P_SQ_COEF  = 32'd3038;
  localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_OFFSET   = 32'd3791;

  // Default divider width.
  localparam int unsigned DATA_W_DEF = 32;

  typedef struct packed {
    logic        req_type;
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] value;
    logic               divide_fault;
  } out_item_t;

endpackage

// ===== hdl/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: integer sensor compensation engine
// Turns raw temperature and pressure words into tenths of a degree and
// pascals with one shared multiplier and one bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid, in_stall, in_data): one transaction per
//   conversion. req_type selects temperature or pressure.
// - Output channel (out_valid, out_stall, out_data): exactly one result per
//   input transaction, in order.
// - Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data):
//   write only while idle; an index beyond the list is ignored.
// - A sequencer steps through the formula with one 32x32 multiplier, one
//   adder/shifter step per cycle and a restoring divider that retires one
//   quotient bit per cycle. The divider dominates the time taken by a result.
//   A new transaction is taken only once the engine is back in idle. A zero
//   divisor ends early, without the divide, with divide_fault set and a zero
//   value.
// - in_stall is high while a transaction is in progress. The result sits in
//   an output register; a new transaction is accepted as soon as the engine
//   is free, even while that result is still stalled. A finished result waits
//   in the engine until the output register is free.
// - Synchronous reset clears the configuration registers, the stored B5 term
//   and the control state; datapath and output data registers are not reset.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bpc_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bpc_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [63:0]                        cfg_data
);

  localparam int unsigned DATA_W = bpc_pkg::DATA_W_DEF;
  localparam int unsigned CNT_W = $clog2(DATA_W + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_T1     = 14'b00000000000010,
    S_T2     = 14'b00000000000100,
    S_T3     = 14'b00000000001000,
    S_P1     = 14'b00000000010000,
    S_P2     = 14'b00000000100000,
    S_P3     = 14'b00000001000000,
    S_P4     = 14'b00000010000000,
    S_P5     = 14'b00000100000000,
    S_DIV    = 14'b00001000000000,
    S_TFIN   = 14'b00010000000000,
    S_PFIN   = 14'b00100000000000,
    S_PC1    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  // Configuration registers and stored B5.
  logic [1:0]  oss;
  logic [63:0] calib_a;
  logic [63:0] calib_b;
  logic [31:0] calib_m;
  logic [31:0] last_b5;

  state_t      state;
  logic [3:0]  step;
  logic        kind;
  logic [31:0] ut, up;
  logic [31:0] r0, r1, r2, r3, sq;

  // Finished result waiting for the output register.
  bpc_pkg::out_item_t result;

  // Shared multiplier operands and product.
  logic [31:0] mul_a, mul_b, prod;

  // Divider.
  logic [DATA_W-1:0] dvd, dvs, quo;
  logic [DATA_W:0]   rem;
  logic [CNT_W-1:0]  dcnt;
  logic              div_neg;
  logic [DATA_W:0]   rem_shift;

  logic        out_full;

  // Coefficients.
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{calib_a[63]}}, calib_a[63:48]};
  assign ac2 = {{16{calib_a[47]}}, calib_a[47:32]};
  assign ac3 = {{16{calib_a[31]}}, calib_a[31:16]};
  assign ac4 = {16'd0, calib_a[15:0]};
  assign ac5 = {16'd0, calib_b[63:48]};
  assign ac6 = {16'd0, calib_b[47:32]};
  assign b1  = {{16{calib_b[31]}}, calib_b[31:16]};
  assign b2  = {{16{calib_b[15]}}, calib_b[15:0]};
  assign mc  = {{16{calib_m[31]}}, calib_m[31:16]};
  assign md  = {{16{calib_m[15]}}, calib_m[15:0]};

  function automatic logic [31:0] B7_X(input logic [31:0] u, input logic [31:0] b3);
    B7_X = u - b3;
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    asr = 32'($signed(v) >>> n);
  endfunction

  assign prod      = mul_a * mul_b;
  assign rem_shift = {rem[DATA_W-1:0], dvd[DATA_W-1]};

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_full;

  // Multiplier operand selection by step.
  always_comb begin
    mul_a = r0;
    mul_b = r0;
    case (state)
      S_T1: begin
        mul_a = ut - ac6;
        mul_b = ac5;
      end
      S_P1: begin
        mul_a = r0;
        mul_b = r0;
      end
      S_P2: begin
        mul_a = b2;
        mul_b = sq;
      end
      S_P3: begin
        mul_a = ac2;
        mul_b = r0;
      end
      S_P4: begin
        mul_a = (step == 4'd0) ? ac3 : b1;
        mul_b = (step == 4'd0) ? r0 : sq;
      end
      S_P5: begin
        mul_a = ac4;
        mul_b = r2 + bpc_pkg::B4_OFFSET;
      end
      S_PFIN: begin
        mul_a = (step == 4'd0) ? (B7_X(up, r1)) : r1;
        mul_b = (step == 4'd0) ? (bpc_pkg::B7_SCALE >> oss) : r1;
      end
      S_PC1: begin
        mul_a = (step == 4'd0) ? r3 : r0;
        mul_b = (step == 4'd0) ? bpc_pkg::P_SQ_COEF : bpc_pkg::P_LIN_COEF;
      end
      default: begin
        mul_a = r0;
        mul_b = r0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      oss     <= '0;
      calib_a <= '0;
      calib_b <= '0;
      calib_m <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpc_pkg::REG_OSS:     oss     <= cfg_data[1:0];
        bpc_pkg::REG_AC1_AC4: calib_a <= cfg_data;
        bpc_pkg::REG_AC5_B2:  calib_b <= cfg_data;
        bpc_pkg::REG_MC_MD:   calib_m <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer: r0..r3 hold intermediates; the divider runs in S_DIV.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
      last_b5  <= '0;
      step     <= '0;
      dcnt     <= '0;
    end else begin
      if (out_full && !out_stall && state != S_DONE) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          step <= '0;
          if (in_valid && !in_stall) begin
            kind  <= in_data.req_type;
            ut    <= {16'd0, in_data.raw_temperature};
            up    <= {13'd0, in_data.raw_pressure};
            state <= (in_data.req_type == bpc_pkg::KIND_TEMP) ? S_T1 : S_P1;
            r0    <= last_b5 - bpc_pkg::B6_OFFSET;
          end
        end
        // Temperature: X1, then divisor check and divide.
        S_T1: begin
          r1    <= asr(prod, 15);
          state <= S_T2;
        end
        S_T2: begin
          r2 <= r1 + md;
          if ((r1 + md) == 32'd0) begin
            result <= '{result_kind: bpc_pkg::KIND_TEMP, value: '0, divide_fault: 1'b1};
            state  <= S_DONE;
          end else begin
            state <= S_T3;
          end
        end
        S_T3: begin
          // Magnitudes for signed truncating division.
          div_neg <= mc[31] ^ r2[31];
          dvd     <= DATA_W'(mc[31] ? -(mc << 11) : (mc << 11));
          dvs     <= DATA_W'(r2[31] ? -r2 : r2);
          rem     <= '0;
          quo     <= '0;
          dcnt    <= CNT_W'(DATA_W);
          state   <= S_DIV;
        end
        // Pressure: B6 squared, B3, B4, B7.
        S_P1: begin
          sq    <= asr(prod, 12);
          state <= S_P2;
        end
        S_P2: begin
          r1    <= asr(prod, 11);
          state <= S_P3;
        end
        S_P3: begin
          r1    <= asr(((ac1 << 2) + r1 + asr(prod, 11)) << oss, 0) + 32'd2;
          state <= S_P4;
          step  <= '0;
        end
        S_P4: begin
          if (step == 4'd0) begin
            r1   <= asr(r1, 2);
            r2   <= asr(prod, 13);
            step <= 4'd1;
          end else begin
            r2    <= asr(r2 + asr(prod, 16) + 32'd2, 2);
            state <= S_P5;
          end
        end
        S_P5: begin
          r3    <= prod >> 15;
          step  <= '0;
          state <= S_PFIN;
          if ((prod >> 15) == 32'd0) begin
            result <= '{result_kind: bpc_pkg::KIND_PRESS, value: '0, divide_fault: 1'b1};
            state  <= S_DONE;
          end
        end
        S_PFIN: begin
          if (step == 4'd0) begin
            // prod = B7; divide B7*2 or B7, fix up after.
            div_neg <= (prod >= bpc_pkg::SIGN_BIT);
            dvd     <= DATA_W'((prod >= bpc_pkg::SIGN_BIT) ? prod : (prod << 1));
            dvs     <= DATA_W'(r3);
            rem     <= '0;
            quo     <= '0;
            dcnt    <= CNT_W'(DATA_W);
            state   <= S_DIV;
          end else begin
            // r0 = p, r1 = ph = p >> 8, prod = ph*ph.
            r3    <= prod;
            step  <= '0;
            state <= S_PC1;
          end
        end
        S_DIV: begin
          if (dcnt != '0) begin
            if (rem_shift >= {1'b0, dvs}) begin
              rem <= rem_shift - {1'b0, dvs};
              quo <= {quo[DATA_W-2:0], 1'b1};
            end else begin
              rem <= rem_shift;
              quo <= {quo[DATA_W-2:0], 1'b0};
            end
            dvd  <= dvd << 1;
            dcnt <= dcnt - 1'b1;
          end else if (kind == bpc_pkg::KIND_TEMP) begin
            r3    <= r1 + (div_neg ? -32'(quo) : 32'(quo));
            state <= S_TFIN;
          end else begin
            r0    <= div_neg ? (32'(quo) << 1) : 32'(quo);
            r1    <= asr(div_neg ? (32'(quo) << 1) : 32'(quo), 8);
            step  <= 4'd1;
            state <= S_PFIN;
          end
        end
        S_TFIN: begin
          last_b5 <= r3;
          result  <= '{result_kind: bpc_pkg::KIND_TEMP, value: asr(r3 + 32'd8, 4),
                       divide_fault: 1'b0};
          state   <= S_DONE;
        end
        S_PC1: begin
          if (step == 4'd0) begin
            r3   <= asr(prod, 16);
            step <= 4'd1;
          end else begin
            result <= '{result_kind: bpc_pkg::KIND_PRESS,
                        value: r0 + asr(r3 + asr(prod, 16) + bpc_pkg::P_OFFSET, 4),
                        divide_fault: 1'b0};
            state  <= S_DONE;
          end
        end
        // Hand the result over once the output register is free.
        S_DONE: begin
          if (!out_full || !out_stall) begin
            out_full <= 1'b1;
            out_data <= result;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && dcnt != '0) |=> (state == S_DIV)) else $error("divider left early");
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_full) |=> out_full) else $error("result lost");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_stall) |=> out_full && $stable(out_data)) else $error("result dropped");

endmodule
